[rtl/rpr_pkg.sv]
// shared types and constants of the response packet reassembler
`default_nettype none

package rpr_pkg;

   localparam logic [1:0] KIND_READ_ERROR   = 2'd0;
   localparam logic [1:0] KIND_WRONG_LENGTH = 2'd1;
   localparam logic [1:0] KIND_START        = 2'd2;
   localparam logic [1:0] KIND_CONT         = 2'd3;

   localparam logic [2:0] STATUS_ACCEPTED     = 3'd0;
   localparam logic [2:0] STATUS_IGNORED      = 3'd1;
   localparam logic [2:0] STATUS_WRONG_LENGTH = 3'd2;
   localparam logic [2:0] STATUS_READ_ERROR   = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG     = 3'd4;
   localparam logic [2:0] STATUS_STRAY        = 3'd5;
   localparam logic [2:0] STATUS_SEQUENCE     = 3'd6;

   localparam logic [15:0] MAX_LEN_RESET   = 16'd4096;
   localparam logic [2:0]  SHORT_HDR_AVAIL = 3'd6;
   localparam logic [2:0]  LONG_HDR_AVAIL  = 3'd5;
   localparam logic [2:0]  CONT_AVAIL      = 3'd7;
   localparam int          PAYLOAD_BYTES   = 7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] length;
      logic        long_hdr;
      logic [5:0]  msg_type;
      logic [6:0]  seq;
      logic [55:0] data;
   } item_type;

   typedef struct packed {
      logic [55:0] payload;
      logic [2:0]  payload_count;
      logic        message_done;
      logic [5:0]  message_type;
      logic        type_valid;
      logic        partial_dropped;
      logic [2:0]  status;
   } result_type;

endpackage

`default_nettype wire

[rtl/rpr_if.sv]
// request and response channel interfaces
`default_nettype none

interface rpr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] packet_data;
   logic        wrong_length;
   logic        read_error;

   modport source (output valid, output packet_data, output wrong_length,
                   output read_error, input ready);
   modport sink   (input valid, input packet_data, input wrong_length,
                   input read_error, output ready);
endinterface

interface rpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [55:0] payload;
   logic [2:0]  payload_count;
   logic        message_done;
   logic [5:0]  message_type;
   logic        type_valid;
   logic        partial_dropped;
   logic [2:0]  status;

   modport source (output valid, output payload, output payload_count,
                   output message_done, output message_type, output type_valid,
                   output partial_dropped, output status, input ready);
   modport sink   (input valid, input payload, input payload_count,
                   input message_done, input message_type, input type_valid,
                   input partial_dropped, input status, output ready);
endinterface

`default_nettype wire

[rtl/response_packet_reassembler.sv]
// response packet reassembler top level
//
// usage: req_if carries one 8-byte link packet per transfer with its
// wrong-length and read-error flags; rsp_if returns exactly one result per
// packet: the payload bytes kept, their count, message-done, message type,
// type-valid, partial-dropped and a status code. csr_wr_en/csr_wr_data write
// the maximum message length (reset 4096); the user must write it only while
// the block is idle, as the block itself does not enforce this.
// path: a packet is decoded into the queue, handled by the back end as it
// leaves the queue and registered in the output register that drives rsp_if.
// throughput: one packet per cycle unless rsp_if stalls; the back end updates
// its message state (bytes due, sequence, fill) per packet, setting that rate.
// reset: synchronous; clears the queue, the message state and the output
// valid flag, and loads the default maximum length.
// stall: the output register holds its result while rsp_if.ready is low; the
// queue keeps taking requests until it is full, then req_if.ready drops.
`default_nettype none

module response_packet_reassembler #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   rpr_req_if.sink     req_if,
   rpr_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import rpr_pkg::*;

   logic     push_valid, push_ready;
   item_type push_data;
   logic     pop_valid, pop_ready;
   item_type pop_data;

   rpr_front u_front (
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rpr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire

[rtl/rpr_front.sv]
// front end: decodes each packet into a classified item
`default_nettype none

module rpr_front (
   rpr_req_if.sink          req_if,
   output logic             push_valid,
   input  logic             push_ready,
   output rpr_pkg::item_type push_data
);
   import rpr_pkg::*;

   logic [7:0] b0;

   assign b0         = req_if.packet_data[7:0];
   assign push_valid = req_if.valid;
   assign req_if.ready = push_ready;

   always_comb begin
      push_data          = '0;
      push_data.long_hdr = b0[6];
      push_data.msg_type = b0[5:0];
      push_data.seq      = b0[6:0];
      push_data.length   = {(b0[6] ? req_if.packet_data[23:16] : 8'd0),
                            req_if.packet_data[15:8]};
      if (req_if.read_error) begin
         push_data.kind = KIND_READ_ERROR;
      end else if (req_if.wrong_length) begin
         push_data.kind = KIND_WRONG_LENGTH;
      end else if (b0[7]) begin
         push_data.kind = KIND_START;
      end else begin
         push_data.kind = KIND_CONT;
      end
      // align payload so that the first payload byte sits in bits 7:0
      if (push_data.kind == KIND_START) begin
         if (b0[6]) begin
            push_data.data = {16'd0, req_if.packet_data[63:24]};
         end else begin
            push_data.data = {8'd0, req_if.packet_data[63:16]};
         end
      end else begin
         push_data.data = req_if.packet_data[63:8];
      end
   end

endmodule

`default_nettype wire

[rtl/rpr_queue.sv]
// small fifo between the front end and the back end
`default_nettype none

module rpr_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rpr_pkg::item_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rpr_pkg::item_type pop_data
);
   import rpr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire, pop_fire;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/rpr_back.sv]
// back end: message state, payload trimming and the response register
`default_nettype none

module rpr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rpr_pkg::item_type pop_data,
   rpr_rsp_if.source         rsp_if
);
   import rpr_pkg::*;

   logic [15:0] max_len_ff;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        drop_long_ff, drop_long_in;
   logic [6:0]  expected_seq_ff, expected_seq_in;
   logic [5:0]  current_type_ff, current_type_in;
   logic        type_ok_ff, type_ok_in;
   logic        synced_ff, synced_in;
   logic [15:0] fill_ff, fill_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        pop_fire;
   logic        take;
   logic [2:0]  cnt;
   logic [2:0]  base;
   logic [15:0] fill_base;
   logic [15:0] room;
   logic [2:0]  keep;

   assign pop_ready = !rsp_valid_ff || rsp_if.ready;
   assign pop_fire  = pop_valid && pop_ready;

   always_comb begin
      bytes_left_in   = bytes_left_ff;
      drop_long_in    = drop_long_ff;
      expected_seq_in = expected_seq_ff;
      current_type_in = current_type_ff;
      type_ok_in      = type_ok_ff;
      synced_in       = synced_ff;
      fill_in         = fill_ff;
      rsp_in          = '0;
      rsp_in.status   = STATUS_ACCEPTED;
      take            = 1'b0;
      cnt             = '0;
      base            = pop_data.long_hdr ? LONG_HDR_AVAIL : SHORT_HDR_AVAIL;
      fill_base       = (pop_data.kind == KIND_START) ? '0 : fill_ff;
      room            = max_len_ff - fill_base;
      keep            = '0;

      case (pop_data.kind)
         KIND_READ_ERROR: begin
            bytes_left_in   = '0;
            expected_seq_in = '0;
            drop_long_in    = 1'b0;
            rsp_in.status   = STATUS_READ_ERROR;
         end
         KIND_WRONG_LENGTH: begin
            rsp_in.status = STATUS_WRONG_LENGTH;
         end
         KIND_START: begin
            rsp_in.partial_dropped = synced_ff && (bytes_left_ff != '0);
            current_type_in        = pop_data.msg_type;
            type_ok_in             = 1'b1;
            expected_seq_in        = '0;
            fill_in                = '0;
            if (synced_ff && (pop_data.length > max_len_ff)) begin
               drop_long_in  = 1'b1;
               bytes_left_in = '0;
               rsp_in.status = STATUS_TOO_LONG;
            end else begin
               drop_long_in  = 1'b0;
               cnt           = (pop_data.length < 16'(base)) ? pop_data.length[2:0] : base;
               bytes_left_in = pop_data.length - 16'(cnt);
               take          = 1'b1;
            end
         end
         KIND_CONT: begin
            if (bytes_left_ff == '0) begin
               if (synced_ff && !drop_long_ff) begin
                  type_ok_in    = 1'b0;
                  rsp_in.status = STATUS_STRAY;
               end else begin
                  rsp_in.status = STATUS_IGNORED;
               end
            end else if (synced_ff && (pop_data.seq != expected_seq_ff)) begin
               type_ok_in    = 1'b0;
               rsp_in.status = STATUS_SEQUENCE;
            end else begin
               expected_seq_in = expected_seq_ff + 1'b1;
               cnt = (bytes_left_ff < 16'(CONT_AVAIL)) ? bytes_left_ff[2:0] : CONT_AVAIL;
               bytes_left_in = bytes_left_ff - 16'(cnt);
               take          = 1'b1;
            end
         end
         default: begin
            rsp_in.status = STATUS_IGNORED;
         end
      endcase

      if (take) begin
         // bytes past the buffer capacity are dropped
         if (max_len_ff <= fill_base) begin
            keep = '0;
         end else if (room < 16'(cnt)) begin
            keep = room[2:0];
         end else begin
            keep = cnt;
         end
         fill_in = fill_base + 16'(keep);
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            rsp_in.payload[8*i +: 8] = (3'(i) < keep) ? pop_data.data[8*i +: 8] : 8'd0;
         end
         rsp_in.payload_count = keep;
         rsp_in.message_done  = (bytes_left_in == '0);
         if (bytes_left_in == '0) begin
            synced_in = 1'b1;
         end
      end

      rsp_in.message_type = current_type_in;
      rsp_in.type_valid   = type_ok_in;

      rsp_valid_in = rsp_valid_ff;
      if (pop_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff      <= MAX_LEN_RESET;
         bytes_left_ff   <= '0;
         drop_long_ff    <= 1'b0;
         expected_seq_ff <= '0;
         current_type_ff <= '0;
         type_ok_ff      <= 1'b1;
         synced_ff       <= 1'b0;
         fill_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (pop_fire) begin
            bytes_left_ff   <= bytes_left_in;
            drop_long_ff    <= drop_long_in;
            expected_seq_ff <= expected_seq_in;
            current_type_ff <= current_type_in;
            type_ok_ff      <= type_ok_in;
            synced_ff       <= synced_in;
            fill_ff         <= fill_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.payload         = rsp_ff.payload;
   assign rsp_if.payload_count   = rsp_ff.payload_count;
   assign rsp_if.message_done    = rsp_ff.message_done;
   assign rsp_if.message_type    = rsp_ff.message_type;
   assign rsp_if.type_valid      = rsp_ff.type_valid;
   assign rsp_if.partial_dropped = rsp_ff.partial_dropped;
   assign rsp_if.status          = rsp_ff.status;

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the response packet reassembler
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpr_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 120;

   class reassembly_board;
      logic [15:0] max_len;
      logic [15:0] bytes_left;
      logic        drop_long;
      logic [6:0]  expected_seq;
      logic [5:0]  current_type;
      logic        type_ok;
      logic        synced;
      logic [16:0] fill;
      result_type  due_results[$];
      int          errors;
      int          checked;
      int          completions;
      int          status_seen[8];

      function new();
         max_len      = MAX_LEN_RESET;
         bytes_left   = '0;
         drop_long    = 1'b0;
         expected_seq = '0;
         current_type = '0;
         type_ok      = 1'b1;
         synced       = 1'b0;
         fill         = '0;
         errors       = 0;
         checked      = 0;
         completions  = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // keep what still fits in the message buffer
      function logic [2:0] take_bytes(logic [63:0] pkt, int first, int cnt,
                                      output logic [55:0] bytes_out);
         int keep;
         keep = 0;
         bytes_out = '0;
         if (fill < max_len) begin
            keep = max_len - fill;
            if (keep > cnt) keep = cnt;
         end
         for (int i = 0; i < keep; i++) begin
            bytes_out[8*i +: 8] = pkt[8*(first+i) +: 8];
         end
         fill = fill + 17'(keep);
         return 3'(keep);
      endfunction

      function void note_packet(logic [63:0] pkt, logic wrong_len, logic read_err);
         result_type r;
         logic [7:0] b0;
         int         len;
         int         first;
         int         avail;
         logic       done;
         r    = '0;
         b0   = pkt[7:0];
         done = 1'b0;
         if (read_err) begin
            bytes_left   = '0;
            expected_seq = '0;
            drop_long    = 1'b0;
            r.status     = STATUS_READ_ERROR;
         end else if (wrong_len) begin
            r.status = STATUS_WRONG_LENGTH;
         end else if (b0[7]) begin
            len   = pkt[15:8];
            first = 2;
            avail = 6;
            r.partial_dropped = synced && (bytes_left != 0);
            current_type = b0[5:0];
            type_ok      = 1'b1;
            expected_seq = '0;
            fill         = '0;
            if (b0[6]) begin
               len   = {pkt[23:16], pkt[15:8]};
               first = 3;
               avail = 5;
            end
            if (synced && len > max_len) begin
               drop_long  = 1'b1;
               bytes_left = '0;
               r.status   = STATUS_TOO_LONG;
            end else begin
               drop_long = 1'b0;
               if (avail > len) avail = len;
               bytes_left = 16'(len - avail);
               r.payload_count = take_bytes(pkt, first, avail, r.payload);
               done = (bytes_left == 0);
            end
         end else begin
            if (bytes_left == 0) begin
               if (synced && !drop_long) begin
                  type_ok  = 1'b0;
                  r.status = STATUS_STRAY;
               end else begin
                  r.status = STATUS_IGNORED;
               end
            end else if (synced && b0[6:0] != expected_seq) begin
               type_ok  = 1'b0;
               r.status = STATUS_SEQUENCE;
            end else begin
               avail        = 7;
               expected_seq = expected_seq + 7'd1;
               if (avail > bytes_left) avail = bytes_left;
               bytes_left   = bytes_left - 16'(avail);
               r.payload_count = take_bytes(pkt, 1, avail, r.payload);
               done = (bytes_left == 0);
            end
         end
         if (done) synced = 1'b1;
         r.message_done = done;
         r.message_type = current_type;
         r.type_valid   = type_ok;
         due_results.push_back(r);
      endfunction

      function void check_field(string name, logic [55:0] want, logic [55:0] got);
         if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (due_results.size() == 0) begin
            $error("result transfer with no packet outstanding");
            errors++;
            return;
         end
         want = due_results.pop_front();
         check_field("payload", want.payload, got.payload);
         check_field("payload_count", want.payload_count, got.payload_count);
         check_field("message_done", want.message_done, got.message_done);
         check_field("message_type", want.message_type, got.message_type);
         check_field("type_valid", want.type_valid, got.type_valid);
         check_field("partial_dropped", want.partial_dropped, got.partial_dropped);
         check_field("status", want.status, got.status);
         checked++;
         status_seen[want.status]++;
         if (want.message_done) completions++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        steady;
   int          packets_in;
   int          quiet_cycles;
   logic [15:0] max_len_steps [PHASES] = '{16'd0, 16'd65535, 16'd30, 16'd1000, 16'd4096};

   reassembly_board board;

   rpr_req_if req_if ();
   rpr_rsp_if rsp_if ();

   response_packet_reassembler dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 27);
   end

   // transfer tracking, result checking and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_packet(req_if.packet_data, req_if.wrong_length, req_if.read_error);
            packets_in++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_result({rsp_if.payload, rsp_if.payload_count, rsp_if.message_done,
                                rsp_if.message_type, rsp_if.type_valid,
                                rsp_if.partial_dropped, rsp_if.status});
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   function automatic logic [63:0] start_packet(logic [5:0] mtype, int len, bit long_hdr);
      logic [63:0] pkt;
      pkt = {$urandom, $urandom};
      pkt[7:0]  = {1'b1, long_hdr, mtype};
      pkt[15:8] = len[7:0];
      if (long_hdr) pkt[23:16] = len[15:8];
      return pkt;
   endfunction

   function automatic logic [63:0] cont_packet(logic [6:0] seq);
      logic [63:0] pkt;
      pkt = {$urandom, $urandom};
      pkt[7:0] = {1'b0, seq};
      return pkt;
   endfunction

   task automatic send_packet(logic [63:0] pkt, logic wrong_len, logic read_err);
      while (!steady && $urandom_range(99) < 27) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.packet_data  <= pkt;
      req_if.wrong_length <= wrong_len;
      req_if.read_error   <= read_err;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_max_len(logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.max_len = value;
   endtask

   task automatic send_message(logic [5:0] mtype, int len, bit long_hdr, int fault_pct,
                               int max_conts);
      int         left;
      int         conts;
      logic [6:0] seq;
      send_packet(start_packet(mtype, len, long_hdr), 1'b0, 1'b0);
      left  = len - (long_hdr ? 5 : 6);
      seq   = '0;
      conts = 0;
      while (left > 0 && conts < max_conts) begin
         if ($urandom_range(99) < fault_pct) begin
            case ($urandom_range(3))
               0: send_packet(cont_packet(seq), 1'b1, 1'b0);
               1: send_packet(cont_packet(seq + 7'd1 + 7'($urandom_range(125))), 1'b0, 1'b0);
               2: begin
                  send_packet({$urandom, $urandom}, 1'($urandom_range(1)), 1'b1);
                  return;
               end
               default: send_packet({$urandom, $urandom}, 1'($urandom_range(1)),
                                    1'($urandom_range(1)));
            endcase
         end
         send_packet(cont_packet(seq), 1'b0, 1'b0);
         seq   = seq + 7'd1;
         left  = left - 7;
         conts++;
      end
   endtask

   task automatic random_traffic();
      int pick;
      int len;
      bit long_hdr;
      pick     = $urandom_range(99);
      long_hdr = ($urandom_range(3) == 0);
      if (pick < 15) begin
         send_packet({$urandom, $urandom}, $urandom_range(9) == 0, $urandom_range(9) == 0);
      end else if (pick < 23) begin
         send_message(6'($urandom_range(63)), $urandom_range(256, 65535), 1'b1, 6, 6);
      end else begin
         len = ($urandom_range(9) == 0) ? $urandom_range(31, 250) : $urandom_range(0, 30);
         send_message(6'($urandom_range(63)), len, long_hdr, 6, 40);
      end
      if ($urandom_range(29) == 0) wait_for_results();
   endtask

   initial begin
      board = new();
      packets_in   = 0;
      quiet_cycles = 0;
      steady       = 1'b0;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_if.valid        <= 1'b0;
      req_if.packet_data  <= '0;
      req_if.wrong_length <= 1'b0;
      req_if.read_error   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // not yet synced: overflow, unchecked sequence, then the synced checks
      write_max_len(16'd3);
      send_packet(cont_packet(7'h00), 1'b0, 1'b0);
      send_packet(start_packet(6'h3F, 10, 1'b0), 1'b0, 1'b0);
      send_packet(cont_packet(7'h55), 1'b0, 1'b0);
      send_packet(cont_packet(7'h00), 1'b0, 1'b0);
      send_packet(start_packet(6'h15, 16'h0100, 1'b1), 1'b0, 1'b0);
      send_packet(cont_packet(7'h00), 1'b0, 1'b0);
      send_packet(start_packet(6'h01, 2, 1'b0), 1'b1, 1'b0);
      send_packet({$urandom, $urandom}, 1'b1, 1'b1);
      wait_for_results();

      write_max_len(16'hFFFF);
      send_packet(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
      send_packet(cont_packet(7'h00), 1'b0, 1'b0);
      send_packet(cont_packet(7'h7F), 1'b0, 1'b0);
      send_packet(64'h0, 1'b0, 1'b0);
      send_packet(start_packet(6'h00, 0, 1'b0), 1'b0, 1'b0);
      send_packet(start_packet(6'h2A, 0, 1'b1), 1'b0, 1'b0);
      send_packet(start_packet(6'h01, 6, 1'b0), 1'b0, 1'b0);
      send_packet(start_packet(6'h02, 5, 1'b1), 1'b0, 1'b0);
      send_packet(start_packet(6'h03, 20, 1'b0), 1'b0, 1'b0);
      send_packet(cont_packet(7'h00), 1'b0, 1'b0);
      send_packet(cont_packet(7'h01), 1'b0, 1'b0);
      send_packet(start_packet(6'h04, 30, 1'b0), 1'b0, 1'b0);
      send_packet({$urandom, $urandom}, 1'b1, 1'b1);
      send_packet(cont_packet(7'h00), 1'b0, 1'b0);
      send_packet(start_packet(6'h05, 8, 1'b0), 1'b0, 1'b0);
      send_packet(cont_packet(7'h00), 1'b1, 1'b0);
      send_packet(cont_packet(7'h00), 1'b0, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_for_results();
         write_max_len(max_len_steps[ph]);
         steady = (ph == 2);
         // long enough for the sequence number to wrap
         if (ph == 1) send_message(6'($urandom_range(63)), 1000, 1'b1, 0, 200);
         while (packets_in < 25 + PHASE_ITEMS * (ph + 1)) random_traffic();
      end
      steady = 1'b0;

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("tb: %0d packets in, %0d results checked, %0d messages completed",
               packets_in, board.checked, board.completions);
      $display({"tb: accepted %0d ignored %0d wrong length %0d read error %0d",
                " too long %0d stray %0d sequence %0d"},
               board.status_seen[STATUS_ACCEPTED], board.status_seen[STATUS_IGNORED],
               board.status_seen[STATUS_WRONG_LENGTH], board.status_seen[STATUS_READ_ERROR],
               board.status_seen[STATUS_TOO_LONG], board.status_seen[STATUS_STRAY],
               board.status_seen[STATUS_SEQUENCE]);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rpr_pkg.sv
rtl/rpr_if.sv
rtl/rpr_front.sv
rtl/rpr_queue.sv
rtl/rpr_back.sv
rtl/response_packet_reassembler.sv
tb/tb.sv
